@@ hdl/hpa_pkg.sv @@
// ---------------------------------------------------------------------------
// hpa_pkg
// Shared widths, constants, types and helpers of the hsv pixel adjust unit.
// ---------------------------------------------------------------------------
package hpa_pkg;

  // fraction bits of the fixed-point hsv values
  localparam int FRAC_BITS = 16;

  // value / saturation width (Q1.F, 0..1.0 inclusive)
  localparam int VW = FRAC_BITS + 1;
  // hue width (Q9.F degrees)
  localparam int HW = FRAC_BITS + 9;
  // divider quotient and numerator widths, divisor is 8 bits
  localparam int QW = FRAC_BITS + 6;
  localparam int NW = QW + 8;

  // register stages from request to result
  localparam int LAT = QW + 9;

  localparam logic [VW-1:0] ONE_Q = VW'(1) << FRAC_BITS;
  localparam logic [HW-1:0] HUE_STEP = HW'(60) << FRAC_BITS;
  localparam logic [HW-1:0] HUE_FULL = HW'(360) << FRAC_BITS;

  // reciprocal multipliers for the constant divisors 100, 255 and 60
  localparam int PCT_SH = FRAC_BITS + 14;
  localparam logic [FRAC_BITS+7:0] PCT_RECIP =
    (FRAC_BITS+8)'(((64'd1 << PCT_SH) + 64'd99) / 64'd100);
  localparam int V_SH = FRAC_BITS + 16;
  localparam logic [FRAC_BITS+8:0] V_RECIP =
    (FRAC_BITS+9)'(((64'd1 << V_SH) + 64'd254) / 64'd255);
  localparam int F_SH = FRAC_BITS + 12;
  localparam logic [FRAC_BITS+6:0] F_RECIP =
    (FRAC_BITS+7)'(((64'd1 << F_SH) + 64'd59) / 64'd60);

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_BRIGHTNESS = 2'd0,
    REG_SATURATION = 2'd1,
    REG_HUE        = 2'd2
  } cfg_reg_t;

  // base sector of the hue, chosen by the largest channel
  typedef enum logic [1:0] {
    BASE_RED   = 2'd0,
    BASE_GREEN = 2'd1,
    BASE_BLUE  = 2'd2
  } base_t;

  // sixty-degree hue sector
  typedef enum logic [2:0] {
    SEC_0 = 3'd0,
    SEC_1 = 3'd1,
    SEC_2 = 3'd2,
    SEC_3 = 3'd3,
    SEC_4 = 3'd4,
    SEC_5 = 3'd5
  } sector_t;

  // side data carried beside the first dividers
  typedef struct packed {
    base_t base;
    logic  neg;
    logic  grey;
    logic  black;
  } side_t;

  // side data carried beside the sector fraction stage
  typedef struct packed {
    logic [VW-1:0] v;
    logic [VW-1:0] s;
    sector_t       sec;
  } mid_t;

  // inputs of the hsv to rgb back end
  typedef struct packed {
    logic [VW-1:0] v;
    logic [VW-1:0] s;
    logic [VW-1:0] f;
    sector_t       sec;
  } rb_in_t;

  // percent offset to fixed point, saturated to +-100, ties away from zero
  function automatic logic signed [FRAC_BITS+1:0] pct_off(input logic [7:0] raw);
    logic signed [7:0] sv;
    logic [6:0] m;
    logic [FRAC_BITS+6:0] t;
    logic [2*FRAC_BITS+14:0] pr;
    logic [FRAC_BITS:0] q;
    sv = signed'(raw);
    if (sv > 8'sd100 || sv < -8'sd100) begin
      m = 7'd100;
    end else if (sv < 8'sd0) begin
      m = 7'(-sv);
    end else begin
      m = 7'(sv);
    end
    t = ((FRAC_BITS+7)'(m) << FRAC_BITS) + (FRAC_BITS+7)'(50);
    // divide by 100 through the reciprocal
    pr = (2*FRAC_BITS+15)'(t) * (2*FRAC_BITS+15)'(PCT_RECIP);
    q = (FRAC_BITS+1)'(pr >> PCT_SH);
    if (sv < 8'sd0) begin
      return -signed'({1'b0, q});
    end
    return signed'({1'b0, q});
  endfunction

  // rounded fixed-point product
  function automatic logic [VW-1:0] qmul(input logic [VW-1:0] a, input logic [VW-1:0] b);
    logic [2*VW-1:0] p;
    p = (2*VW)'(a) * (2*VW)'(b) + ((2*VW)'(1) << (FRAC_BITS - 1));
    return VW'(p >> FRAC_BITS);
  endfunction

  // fixed-point fraction to rounded byte
  function automatic logic [7:0] to_byte(input logic [VW-1:0] x);
    logic [VW+7:0] p;
    p = ((VW+8)'(x) << 8) - (VW+8)'(x) + ((VW+8)'(1) << (FRAC_BITS - 1));
    return 8'(p >> FRAC_BITS);
  endfunction

endpackage

@@ hdl/hpa_div.sv @@
// ---------------------------------------------------------------------------
// hpa_div
// Pipelined restoring divider, one quotient bit per stage, 8-bit divisor.
// ---------------------------------------------------------------------------
module hpa_div (
  input  logic                   clk,
  input  logic                   en,
  input  logic [hpa_pkg::NW-1:0] num,
  input  logic [7:0]             den,
  output logic [hpa_pkg::QW-1:0] quo
);

  logic [7:0]             rem  [0:hpa_pkg::QW-1];
  logic [7:0]             dv   [0:hpa_pkg::QW-1];
  logic [hpa_pkg::QW-1:0] low  [0:hpa_pkg::QW];
  logic [8:0]             trial[0:hpa_pkg::QW-1];
  logic [7:0]             nrem [0:hpa_pkg::QW-1];
  logic [hpa_pkg::QW-1:0] qb;

  // trial subtraction of each stage
  always_comb begin
    for (int i = 0; i < hpa_pkg::QW; i++) begin
      trial[i] = {rem[i], low[i][hpa_pkg::QW-1]};
      qb[i]    = (trial[i] >= {1'b0, dv[i]});
      nrem[i]  = qb[i] ? 8'(trial[i] - {1'b0, dv[i]}) : trial[i][7:0];
    end
  end

  // stage registers, the low word shifts the quotient in
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= num[hpa_pkg::NW-1:hpa_pkg::QW];
      low[0] <= num[hpa_pkg::QW-1:0];
      dv[0]  <= den;
      for (int i = 0; i < hpa_pkg::QW - 1; i++) begin
        rem[i+1] <= nrem[i];
        dv[i+1]  <= dv[i];
      end
      for (int i = 0; i < hpa_pkg::QW; i++) begin
        low[i+1] <= {low[i][hpa_pkg::QW-2:0], qb[i]};
      end
    end
  end

  assign quo = low[hpa_pkg::QW];

endmodule

@@ hdl/hpa_rebuild.sv @@
// ---------------------------------------------------------------------------
// hpa_rebuild
// Six-sector hsv to rgb back end: products, sector select, byte rounding.
// ---------------------------------------------------------------------------
module hpa_rebuild (
  input  logic            clk,
  input  logic            en,
  input  hpa_pkg::rb_in_t rb,
  output logic [7:0]      red,
  output logic [7:0]      green,
  output logic [7:0]      blue
);

  logic [hpa_pkg::VW-1:0] p1, sf1, s1f1, v1;
  hpa_pkg::sector_t       sec1;
  logic [hpa_pkg::VW-1:0] p2, q2, t2, v2;
  hpa_pkg::sector_t       sec2;
  logic [hpa_pkg::VW-1:0] rs, gs, bs;

  // first products
  always_ff @(posedge clk) begin
    if (en) begin
      p1   <= hpa_pkg::qmul(rb.v, hpa_pkg::ONE_Q - rb.s);
      sf1  <= hpa_pkg::qmul(rb.s, rb.f);
      s1f1 <= hpa_pkg::qmul(rb.s, hpa_pkg::ONE_Q - rb.f);
      v1   <= rb.v;
      sec1 <= rb.sec;
    end
  end

  // second products
  always_ff @(posedge clk) begin
    if (en) begin
      q2   <= hpa_pkg::qmul(v1, hpa_pkg::ONE_Q - sf1);
      t2   <= hpa_pkg::qmul(v1, hpa_pkg::ONE_Q - s1f1);
      p2   <= p1;
      v2   <= v1;
      sec2 <= sec1;
    end
  end

  // sector select
  always_comb begin
    unique case (sec2)
      hpa_pkg::SEC_0: begin rs = v2; gs = t2; bs = p2; end
      hpa_pkg::SEC_1: begin rs = q2; gs = v2; bs = p2; end
      hpa_pkg::SEC_2: begin rs = p2; gs = v2; bs = t2; end
      hpa_pkg::SEC_3: begin rs = p2; gs = q2; bs = v2; end
      hpa_pkg::SEC_4: begin rs = t2; gs = p2; bs = v2; end
      default:        begin rs = v2; gs = p2; bs = q2; end
    endcase
  end

  // byte rounding into the output register
  always_ff @(posedge clk) begin
    if (en) begin
      red   <= hpa_pkg::to_byte(rs);
      green <= hpa_pkg::to_byte(gs);
      blue  <= hpa_pkg::to_byte(bs);
    end
  end

endmodule

@@ hdl/hsv_pixel_adjust_unit.sv @@
// Throughput: one pixel per cycle unless the output stalls; depth is set by the bit-per-stage
// saturation and hue dividers, value and sector fraction use reciprocals.
// A stall at the output holds the whole pipeline in place.
// Reset (rst, synchronous) clears the valid bits and the three offsets.
// ---------------------------------------------------------------------------
// hsv_pixel_adjust_unit
// RGB to HSV, offset and clamp, HSV back to RGB, one pixel per cycle.
// ---------------------------------------------------------------------------
module hsv_pixel_adjust_unit (
  input  logic        clk,
  input  logic        rst,
  // pixel requests
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // red_in[7:0], green_in[15:8], blue_in[23:16]
  // adjusted pixels
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // red_out[7:0], green_out[15:8], blue_out[23:16]
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [9:0]  cfg_data
);

  localparam int F  = hpa_pkg::FRAC_BITS;
  localparam int VW = hpa_pkg::VW;
  localparam int HW = hpa_pkg::HW;
  localparam int QW = hpa_pkg::QW;
  localparam int NW = hpa_pkg::NW;

  logic en;
  logic vld [0:hpa_pkg::LAT-1];

  logic signed [F+1:0] boff_q, soff_q;
  logic signed [9:0]   hoff;
  logic signed [9:0]   hraw;

  // configuration registers, brightness and saturation offsets held in converted form
  assign cfg_ready = 1'b1;
  assign hraw = signed'(cfg_data);
  always_ff @(posedge clk) begin
    if (rst) begin
      boff_q <= '0;
      soff_q <= '0;
      hoff   <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        hpa_pkg::REG_BRIGHTNESS: boff_q <= hpa_pkg::pct_off(cfg_data[7:0]);
        hpa_pkg::REG_SATURATION: soff_q <= hpa_pkg::pct_off(cfg_data[7:0]);
        hpa_pkg::REG_HUE: begin
          if (hraw > 10'sd360) hoff <= 10'sd360;
          else if (hraw < -10'sd360) hoff <= -10'sd360;
          else hoff <= hraw;
        end
        default: ;
      endcase
    end
  end

  // pipeline advance
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[hpa_pkg::LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < hpa_pkg::LAT; i++) vld[i] <= 1'b0;
    end else if (en) begin
      vld[0] <= s_tvalid;
      for (int i = 1; i < hpa_pkg::LAT; i++) vld[i] <= vld[i-1];
    end
  end

  // front: max, min, hue numerator
  logic [7:0] r_in, g_in, b_in, mx_c, mn_c, mag_c;
  logic signed [8:0] num_c;
  hpa_pkg::base_t base_c;

  assign r_in = s_tdata[7:0];
  assign g_in = s_tdata[15:8];
  assign b_in = s_tdata[23:16];

  always_comb begin
    mx_c = (r_in > g_in) ? r_in : g_in;
    mn_c = (r_in < g_in) ? r_in : g_in;
    if (b_in > mx_c) mx_c = b_in;
    if (b_in < mn_c) mn_c = b_in;
    priority if (r_in == mx_c) begin
      base_c = hpa_pkg::BASE_RED;
      num_c  = signed'({1'b0, g_in}) - signed'({1'b0, b_in});
    end else if (g_in == mx_c) begin
      base_c = hpa_pkg::BASE_GREEN;
      num_c  = signed'({1'b0, b_in}) - signed'({1'b0, r_in});
    end else begin
      base_c = hpa_pkg::BASE_BLUE;
      num_c  = signed'({1'b0, r_in}) - signed'({1'b0, g_in});
    end
    mag_c = (num_c < 0) ? 8'(-num_c) : 8'(num_c);
  end

  logic [7:0] mx1, delta1, mag1;
  hpa_pkg::side_t side1;

  always_ff @(posedge clk) begin
    if (en) begin
      mx1         <= mx_c;
      delta1      <= mx_c - mn_c;
      mag1        <= mag_c;
      side1.base  <= base_c;
      side1.neg   <= (num_c < 0);
      side1.grey  <= (mx_c == mn_c);
      side1.black <= (mx_c == 8'd0);
    end
  end

  // dividers for saturation and hue magnitude, value by reciprocal
  logic [NW-1:0]    s_num, h_num;
  logic [F+7:0]     v_num;
  logic [2*F+16:0]  v_prod;
  logic [7:0]       s_den, h_den;
  logic [13:0]      mag60;
  logic [QW-1:0]    sq, hq;

  assign mag60  = 14'(mag1) * 14'd60;
  assign s_num  = (NW'(delta1) << F) + NW'(mx1[7:1]);
  assign s_den  = (mx1 == 8'd0) ? 8'd1 : mx1;
  assign h_num  = (NW'(mag60) << F) + NW'(delta1[7:1]);
  assign h_den  = (delta1 == 8'd0) ? 8'd1 : delta1;
  assign v_num  = ((F+8)'(mx1) << F) + (F+8)'(127);
  assign v_prod = (2*F+17)'(v_num) * (2*F+17)'(hpa_pkg::V_RECIP);

  hpa_div u_div_s (.clk(clk), .en(en), .num(s_num), .den(s_den), .quo(sq));
  hpa_div u_div_h (.clk(clk), .en(en), .num(h_num), .den(h_den), .quo(hq));

  hpa_pkg::side_t sd [0:QW];
  logic [VW-1:0]  vd [0:QW];
  always_ff @(posedge clk) begin
    if (en) begin
      sd[0] <= side1;
      vd[0] <= VW'(v_prod >> hpa_pkg::V_SH);
      for (int i = 1; i <= QW; i++) begin
        sd[i] <= sd[i-1];
        vd[i] <= vd[i-1];
      end
    end
  end

  // hue assembly and offset sums
  logic signed [HW+1:0] hb_c, hq_c, hs_c;
  logic [HW-1:0]        h1;
  logic signed [VW+1:0] vs1, ss1;
  logic [VW-1:0]        s_raw;

  always_comb begin
    unique case (sd[QW].base)
      hpa_pkg::BASE_RED:   hb_c = '0;
      hpa_pkg::BASE_GREEN: hb_c = signed'((HW+2)'(hpa_pkg::HUE_STEP) << 1);
      default:             hb_c = signed'((HW+2)'(hpa_pkg::HUE_STEP) << 2);
    endcase
    hq_c = signed'((HW+2)'(hq));
    hs_c = sd[QW].neg ? hb_c - hq_c : hb_c + hq_c;
    if (hs_c < 0) hs_c = hs_c + signed'((HW+2)'(hpa_pkg::HUE_FULL));
    if (sd[QW].grey) hs_c = '0;
    s_raw = sd[QW].black ? '0 : sq[VW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h1  <= HW'(hs_c);
      vs1 <= (VW+2)'(signed'({1'b0, vd[QW]})) + (VW+2)'(boff_q);
      ss1 <= (VW+2)'(signed'({1'b0, s_raw})) + (VW+2)'(soff_q);
    end
  end

  // clamping
  logic signed [HW+1:0] hh_c;
  logic [HW-1:0]        h2;
  logic [VW-1:0]        v2, s2;

  assign hh_c = signed'((HW+2)'(h1)) + ((HW+2)'(hoff) <<< F);

  always_ff @(posedge clk) begin
    if (en) begin
      if (vs1 < 0) v2 <= '0;
      else if (vs1 > signed'((VW+2)'(hpa_pkg::ONE_Q))) v2 <= hpa_pkg::ONE_Q;
      else v2 <= VW'(vs1);
      if (ss1 < 0) s2 <= '0;
      else if (ss1 > signed'((VW+2)'(hpa_pkg::ONE_Q))) s2 <= hpa_pkg::ONE_Q;
      else s2 <= VW'(ss1);
      if (hh_c <= 0 || hh_c >= signed'((HW+2)'(hpa_pkg::HUE_FULL))) h2 <= '0;
      else h2 <= HW'(hh_c);
    end
  end

  // sector and remainder
  hpa_pkg::sector_t sec_c, sec3;
  logic [HW-1:0]    sbase_c;
  logic [F+5:0]     fnum3;
  logic [VW-1:0]    v3, s3;

  always_comb begin
    priority if (h2 >= HW'(5) * hpa_pkg::HUE_STEP) begin
      sec_c = hpa_pkg::SEC_5; sbase_c = HW'(5) * hpa_pkg::HUE_STEP;
    end else if (h2 >= HW'(4) * hpa_pkg::HUE_STEP) begin
      sec_c = hpa_pkg::SEC_4; sbase_c = HW'(4) * hpa_pkg::HUE_STEP;
    end else if (h2 >= HW'(3) * hpa_pkg::HUE_STEP) begin
      sec_c = hpa_pkg::SEC_3; sbase_c = HW'(3) * hpa_pkg::HUE_STEP;
    end else if (h2 >= HW'(2) * hpa_pkg::HUE_STEP) begin
      sec_c = hpa_pkg::SEC_2; sbase_c = HW'(2) * hpa_pkg::HUE_STEP;
    end else if (h2 >= hpa_pkg::HUE_STEP) begin
      sec_c = hpa_pkg::SEC_1; sbase_c = hpa_pkg::HUE_STEP;
    end else begin
      sec_c = hpa_pkg::SEC_0; sbase_c = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sec3  <= sec_c;
      fnum3 <= (F+6)'(h2 - sbase_c) + (F+6)'(30);
      v3    <= v2;
      s3    <= s2;
    end
  end

  // sector fraction, divide by 60 through the reciprocal
  logic [2*F+12:0] fprod;
  logic [VW-1:0]   f4;
  hpa_pkg::mid_t   md;
  hpa_pkg::rb_in_t rb;

  assign fprod = (2*F+13)'(fnum3) * (2*F+13)'(hpa_pkg::F_RECIP);

  always_ff @(posedge clk) begin
    if (en) begin
      f4     <= VW'(fprod >> hpa_pkg::F_SH);
      md.v   <= v3;
      md.s   <= s3;
      md.sec <= sec3;
    end
  end

  assign rb.v   = md.v;
  assign rb.s   = md.s;
  assign rb.sec = md.sec;
  assign rb.f   = f4;

  // back end to rgb
  hpa_rebuild u_rebuild (
    .clk  (clk),
    .en   (en),
    .rb   (rb),
    .red  (m_tdata[7:0]),
    .green(m_tdata[15:8]),
    .blue (m_tdata[23:16])
  );

`ifndef SYNTHESIS
  // an accepted request enters the first stage
  a_enter: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> vld[0])
    else $error("accepted pixel missing from first stage");

  // a held result blocks new requests
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("request taken while output stalled");

  // a held result stays in place
  a_keep: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result lost or changed");

  // no result appears when the stage before the last is empty and the pipeline advances
  a_none: assert property (@(posedge clk) disable iff (rst)
    !vld[hpa_pkg::LAT-2] && en |=> !m_tvalid)
    else $error("result appeared without a pixel behind it");
`endif

endmodule
